### design/crti_pkg.sv
// ----------------------------------------------------------------------------
// Cooling-rate table interpolator package
// Shared widths, function codes, bin thresholds and power-of-two roots.
// ----------------------------------------------------------------------------
`default_nettype none
package crti_pkg;

    localparam int STEP_W    = 12;
    localparam int FRAC_BITS = 20;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_SET   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [31:0] LOG2_10_Q30 = 32'd3566893132;

    localparam logic signed [15:0] ABUND_THR [7] = '{
        -16'sd14336, -16'sd10240, -16'sd7168, -16'sd5120,
        -16'sd3072, -16'sd1024, 16'sd1024
    };

    // Returns 2^(2^-k) in Q30, each root taken from the previous one by an
    // integer square root, starting from 2.0.
    function automatic logic [31:0] pow_root(input int k);
        logic [63:0] c;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        c = 64'd1 << 31;
        for (int i = 0; i < k; i++) begin
            n = c << 30;
            r = '0;
            b = 64'd1 << 62;
            for (int s = 0; s < 32; s++) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            c = r;
        end
        return c[31:0];
    endfunction

endpackage
`default_nettype wire

### design/cooling_rate_table_interp_core.sv
// ----------------------------------------------------------------------------
// Cooling-rate table interpolator
// Eight log cooling-rate tables, linear interpolation and 10^x conversion.
// ----------------------------------------------------------------------------
// A request is taken at each rising edge where start is high; busy is always
// low, so one request may follow another in every cycle.
// Function load writes one rate entry, function set writes a table's start
// temperature and line count; neither gives a result.
// A query gives one result on the o_ result ports, marked by o_result_valid
// for one cycle. The result passes through the two 16-stage dividers
// (temperature by step, interpolation by step) and the 20-stage
// power-of-two multiplier chain; the rate table reads are registered in a
// dual-read memory.
// Throughput is one request per cycle, sustained.
// The temperature step is written through i_cfg_wr_en and i_cfg_wr_data. The user
// must write it only while no query is in flight; the block does not enforce it.
// Reset clears the step to 205, the table starts and line counts to zero and
// all pipeline valid bits; rate entries are undefined until loaded.
// There is no back-pressure: the receiver takes every result when strobed.
// ----------------------------------------------------------------------------
`default_nettype none
module cooling_rate_table_interp_core #(
    parameter int MAX_ENTRIES = 128
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_func,
    input  wire logic [2:0]                  i_table_sel,
    input  wire logic [6:0]                  i_entry_index,
    input  wire logic signed [15:0]          i_log_rate_value,
    input  wire logic [15:0]                 i_log_temp,
    input  wire logic [7:0]                  i_line_count,
    input  wire logic signed [15:0]          i_log_abundance,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [crti_pkg::STEP_W-1:0] i_cfg_wr_data,
    output logic                             o_result_valid,
    output logic [15:0]                      o_rate_mantissa,
    output logic signed [7:0]                o_rate_exponent,
    output logic                             o_rate_is_zero,
    output logic signed [15:0]               o_log_rate_out,
    output logic                             o_clamped_high
);
    localparam int SW_  = crti_pkg::STEP_W;
    localparam int AW   = $clog2(8 * MAX_ENTRIES);
    localparam int LW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int LOW  = LW + SW_;
    localparam int CW   = (LOW > 16) ? LOW : 16;

    typedef struct packed {
        logic           is_load;
        logic           is_query;
        logic [2:0]     tab;
        logic [LW-1:0]  n;
        logic           below;
        logic           high;
        logic [AW-1:0]  waddr;
        logic [15:0]    wdata;
    } t_s1;

    typedef struct packed {
        logic        direct;
        logic [15:0] xd;
        logic        below;
        logic        high;
    } t_s3;

    typedef struct packed {
        logic [7:0]  e;
        logic [15:0] x;
        logic        below;
        logic        high;
    } t_pw;

    logic [SW_-1:0] r_step;
    logic [15:0]    r_tstart [8];
    logic [LW-1:0]  r_tlines [8];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= SW_'(205);
        end else if (i_cfg_wr_en) begin
            r_step <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_tstart[i] <= '0;
                r_tlines[i] <= '0;
            end
        end else if (start && i_func == crti_pkg::FUNC_SET) begin
            r_tstart[i_table_sel] <= i_log_temp;
            r_tlines[i_table_sel] <= (32'(i_line_count) > MAX_ENTRIES) ?
                LW'(MAX_ENTRIES) : LW'(i_line_count);
        end
    end

    // Accept stage: bin choice and table lookup.
    logic [2:0]    n_tab;
    logic [LW-1:0] n_n;
    logic [15:0]   n_start;

    always_comb begin
        n_tab = '0;
        for (int k = 0; k < 7; k++) begin
            n_tab = n_tab + 3'(i_log_abundance > crti_pkg::ABUND_THR[k]);
        end
        n_n     = r_tlines[n_tab];
        n_start = r_tstart[n_tab];
    end

    logic          r1_vld;
    logic          r1_load;
    logic          r1_query;
    logic [2:0]    r1_tab;
    logic [LW-1:0] r1_n;
    logic          r1_below;
    logic [15:0]   r1_d;
    logic [AW-1:0] r1_waddr;
    logic [15:0]   r1_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
        r1_load  <= (i_func == crti_pkg::FUNC_LOAD) && (32'(i_entry_index) < MAX_ENTRIES);
        r1_query <= i_func == crti_pkg::FUNC_QUERY;
        r1_tab   <= n_tab;
        r1_n     <= n_n;
        r1_below <= (n_n == '0) || (i_log_temp < n_start);
        r1_d     <= i_log_temp - n_start;
        r1_waddr <= AW'(i_table_sel) * AW'(MAX_ENTRIES) + AW'(i_entry_index);
        r1_wdata <= i_log_rate_value;
    end

    // Range check of the offset against the last table point.
    logic [LOW-1:0] n_last_off;
    t_s1            n_s1;

    always_comb begin
        n_last_off     = LOW'(LW'(r1_n - 1'b1)) * LOW'(r_step);
        n_s1.is_load   = r1_load;
        n_s1.is_query  = r1_query;
        n_s1.tab       = r1_tab;
        n_s1.n         = r1_n;
        n_s1.below     = r1_below;
        n_s1.high      = !r1_below && (CW'(r1_d) > CW'(n_last_off));
        n_s1.waddr     = r1_waddr;
        n_s1.wdata     = r1_wdata;
    end

    logic           d1_vld;
    logic [15:0]    d1_quo;
    logic [SW_-1:0] d1_rem;
    logic [$bits(t_s1)-1:0] d1_side_raw;
    t_s1            d1_side;

    crti_div #(.QW(16), .SW($bits(t_s1))) u_div_idx (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r1_vld),
        .i_rem  ('0),
        .i_num  (r1_d),
        .i_div  (r_step),
        .i_side (n_s1),
        .o_vld  (d1_vld),
        .o_quo  (d1_quo),
        .o_rem  (d1_rem),
        .o_side (d1_side_raw)
    );
    assign d1_side = t_s1'(d1_side_raw);

    // Neighbor selection and table reads.
    logic [15:0]    n_j;
    logic [SW_-1:0] n_r;
    logic [IW-1:0]  n_nm1;
    logic [IW-1:0]  n_idx0;
    logic [IW-1:0]  n_idx1;
    logic [AW-1:0]  n_base;
    logic [AW-1:0]  n_raddr0;
    logic [AW-1:0]  n_raddr1;

    always_comb begin
        n_j    = (r_step == '0) ? '0 : d1_quo;
        n_r    = (r_step == '0) ? '0 : d1_rem;
        n_nm1  = IW'(d1_side.n - 1'b1);
        n_idx0 = d1_side.high ? n_nm1 : n_j[IW-1:0];
        if (d1_side.high) begin
            n_idx1 = n_nm1;
        end else if ((17'(n_j) + 17'd1) < 17'(d1_side.n)) begin
            n_idx1 = IW'(n_j + 16'd1);
        end else begin
            n_idx1 = n_nm1;
        end
        n_base   = AW'(d1_side.tab) * AW'(MAX_ENTRIES);
        n_raddr0 = n_base + AW'(n_idx0);
        n_raddr1 = n_base + AW'(n_idx1);
    end

    logic [15:0] m_rd0;
    logic [15:0] m_rd1;

    crti_store #(.DEPTH(8 * MAX_ENTRIES), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (d1_vld && d1_side.is_load),
        .i_waddr (d1_side.waddr),
        .i_wdata (d1_side.wdata),
        .i_raddr0(n_raddr0),
        .i_raddr1(n_raddr1),
        .o_rdata0(m_rd0),
        .o_rdata1(m_rd1)
    );

    logic           r2_vld;
    logic           r2_below;
    logic           r2_high;
    logic           r2_direct;
    logic [SW_-1:0] r2_r;
    logic [SW_-1:0] r2_rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= d1_vld && d1_side.is_query;
        end
        r2_below  <= d1_side.below;
        r2_high   <= d1_side.high;
        r2_direct <= d1_side.high || (n_r == '0);
        r2_r      <= n_r;
        r2_rs     <= r_step - n_r;
    end

    // Weighted neighbor products.
    logic               r3_vld;
    logic signed [28:0] r3_p0;
    logic signed [28:0] r3_p1;
    t_s3                r3_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_p0       <= 29'($signed(m_rd0) * $signed({1'b0, r2_rs}));
        r3_p1       <= 29'($signed(m_rd1) * $signed({1'b0, r2_r}));
        r3_s.direct <= r2_direct;
        r3_s.xd     <= m_rd0;
        r3_s.below  <= r2_below;
        r3_s.high   <= r2_high;
    end

    logic signed [29:0] n_biased;
    assign n_biased = 30'(r3_p0) + 30'(r3_p1) + $signed({3'b0, r_step, 15'd0})
                    + $signed(30'(r_step >> 1));

    logic           d2_vld;
    logic [15:0]    d2_quo;
    logic [SW_-1:0] d2_rem;
    logic [$bits(t_s3)-1:0] d2_side_raw;
    t_s3            d2_side;

    crti_div #(.QW(16), .SW($bits(t_s3))) u_div_interp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r3_vld),
        .i_rem  (n_biased[16+SW_-1:16]),
        .i_num  (n_biased[15:0]),
        .i_div  (r_step),
        .i_side (r3_s),
        .o_vld  (d2_vld),
        .o_quo  (d2_quo),
        .o_rem  (d2_rem),
        .o_side (d2_side_raw)
    );
    assign d2_side = t_s3'(d2_side_raw);

    // Scale by log2(10) into a Q40 power of two.
    logic [15:0] n_x;
    assign n_x = d2_side.direct ? d2_side.xd : (d2_quo ^ 16'h8000);

    logic               r5_vld;
    logic signed [48:0] r5_y;
    logic [15:0]        r5_x;
    logic               r5_below;
    logic               r5_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= d2_vld && (d2_rem == d2_rem);
        end
        r5_y     <= 49'($signed(n_x) * $signed({1'b0, crti_pkg::LOG2_10_Q30}));
        r5_x     <= n_x;
        r5_below <= d2_side.below;
        r5_high  <= d2_side.high;
    end

    t_pw n_pw;
    always_comb begin
        n_pw.e     = r5_y[47:40];
        n_pw.x     = r5_x;
        n_pw.below = r5_below;
        n_pw.high  = r5_high;
    end

    logic        p_vld;
    logic [31:0] p_mant;
    logic [$bits(t_pw)-1:0] p_side_raw;
    t_pw         p_side;

    crti_pow #(.SW($bits(t_pw))) u_pow (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r5_vld),
        .i_frac (r5_y[39:20]),
        .i_side (n_pw),
        .o_vld  (p_vld),
        .o_mant (p_mant),
        .o_side (p_side_raw)
    );
    assign p_side = t_pw'(p_side_raw);

    logic [16:0] n_mant;
    assign n_mant = 17'((p_mant + 32'd16384) >> 15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= p_vld;
        end
        if (p_side.below) begin
            o_rate_mantissa <= '0;
            o_rate_exponent <= '0;
            o_rate_is_zero  <= 1'b1;
            o_log_rate_out  <= '0;
            o_clamped_high  <= 1'b0;
        end else begin
            o_rate_mantissa <= n_mant[16] ? 16'h8000 : n_mant[15:0];
            o_rate_exponent <= n_mant[16] ? p_side.e + 8'd1 : p_side.e;
            o_rate_is_zero  <= 1'b0;
            o_log_rate_out  <= p_side.x;
            o_clamped_high  <= p_side.high;
        end
    end
endmodule
`default_nettype wire

### design/crti_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage by a 12-bit divisor, with a request sideband.
// ----------------------------------------------------------------------------
`default_nettype none
module crti_div #(
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire logic [crti_pkg::STEP_W-1:0]   i_rem,
    input  wire logic [QW-1:0]                 i_num,
    input  wire logic [crti_pkg::STEP_W-1:0]   i_div,
    input  wire logic [SW-1:0]                 i_side,
    output logic                               o_vld,
    output logic [QW-1:0]                      o_quo,
    output logic [crti_pkg::STEP_W-1:0]        o_rem,
    output logic [SW-1:0]                      o_side
);
    localparam int DW = crti_pkg::STEP_W;

    logic [QW:0]   r_vld;
    logic [DW-1:0] r_rem  [QW+1];
    logic [QW-1:0] r_num  [QW+1];
    logic [SW-1:0] r_side [QW+1];

    assign r_vld[0]  = i_vld;
    assign r_rem[0]  = i_rem;
    assign r_num[0]  = i_num;
    assign r_side[0] = i_side;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   n_t;
        logic          n_ge;
        logic [DW-1:0] n_rem;
        assign n_t   = {r_rem[k], r_num[k][QW-1]};
        assign n_ge  = n_t >= {1'b0, i_div};
        assign n_rem = n_ge ? DW'(n_t - {1'b0, i_div}) : n_t[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1]  <= n_rem;
            r_num[k+1]  <= {r_num[k][QW-2:0], n_ge};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_vld  = r_vld[QW];
    assign o_quo  = r_num[QW];
    assign o_rem  = r_rem[QW];
    assign o_side = r_side[QW];
endmodule
`default_nettype wire

### design/crti_pow.sv
// ----------------------------------------------------------------------------
// Power-of-two mantissa chain
// One stage per fraction bit multiplies the Q30 mantissa by a fixed root when that bit is set.
// ----------------------------------------------------------------------------
`default_nettype none
module crti_pow #(
    parameter int SW = 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_vld,
    input  wire logic [crti_pkg::FRAC_BITS-1:0] i_frac,
    input  wire logic [SW-1:0]                  i_side,
    output logic                                o_vld,
    output logic [31:0]                         o_mant,
    output logic [SW-1:0]                       o_side
);
    localparam int FB = crti_pkg::FRAC_BITS;

    logic [FB:0]   r_vld;
    logic [31:0]   r_m    [FB+1];
    logic [FB-1:0] r_f    [FB+1];
    logic [SW-1:0] r_side [FB+1];

    assign r_vld[0]  = i_vld;
    assign r_m[0]    = 32'h4000_0000;
    assign r_f[0]    = i_frac;
    assign r_side[0] = i_side;

    for (genvar k = 0; k < FB; k++) begin : g_stage
        localparam logic [31:0] CK = crti_pkg::pow_root(k + 1);
        logic [63:0] n_prod;
        assign n_prod = r_m[k] * CK + (64'd1 << 29);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_m[k+1]    <= r_f[k][FB-1] ? n_prod[61:30] : r_m[k];
            r_f[k+1]    <= {r_f[k][FB-2:0], 1'b0};
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_vld  = r_vld[FB];
    assign o_mant = r_m[FB];
    assign o_side = r_side[FB];
endmodule
`default_nettype wire

### design/crti_store.sv
// ----------------------------------------------------------------------------
// Rate entry store
// Two mirrored synchronous memories give two registered reads per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module crti_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr0,
    input  wire logic [AW-1:0] i_raddr1,
    output logic [15:0]        o_rdata0,
    output logic [15:0]        o_rdata1
);
    logic [15:0] r_mem0 [DEPTH];
    logic [15:0] r_mem1 [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem0[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem0[i_raddr0];
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem1[i_waddr] <= i_wdata;
        end
        o_rdata1 <= r_mem1[i_raddr1];
    end
endmodule
`default_nettype wire

### design/crti_checker.sv
// ----------------------------------------------------------------------------
// Cooling-rate table interpolator port checker
// Watches the result ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none
module crti_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        busy,
    input wire logic        o_result_valid,
    input wire logic [15:0] o_rate_mantissa,
    input wire logic [7:0]  o_rate_exponent,
    input wire logic        o_rate_is_zero,
    input wire logic [15:0] o_log_rate_out,
    input wire logic        o_clamped_high
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy asserted");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_result_valid)
        else $error("result strobe right after reset");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_rate_is_zero) |-> (o_rate_mantissa == 16'd0 &&
        o_rate_exponent == 8'd0 && o_log_rate_out == 16'd0 && !o_clamped_high))
        else $error("zero result with nonzero fields");

    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_rate_is_zero) |-> o_rate_mantissa[15])
        else $error("mantissa not normalized");
endmodule

bind cooling_rate_table_interp_core crti_checker u_crti_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_rate_mantissa(o_rate_mantissa),
    .o_rate_exponent(o_rate_exponent),
    .o_rate_is_zero (o_rate_is_zero),
    .o_log_rate_out (o_log_rate_out),
    .o_clamped_high (o_clamped_high)
);
`default_nettype wire

### dv/cooling_rate_table_interp_core_test.sv
// ----------------------------------------------------------------------------
// Cooling-rate table interpolator testbench
// Loads tables, sets starts and counts and sends queries with random gaps.
// A directed table comes first, then random traffic, with several step values.
// Every query result is checked against a predictor of the interpolation and
// the power-of-ten conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cooling_rate_table_interp_core_test;

    localparam int ENTRIES   = 128;
    localparam int FILL      = 21;
    localparam int LATENCY   = 56;
    localparam int MAX_CYCLE = 400000;
    localparam int FB        = crti_pkg::FRAC_BITS;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         tsel;
        logic [6:0]         eidx;
        logic signed [15:0] rate;
        logic [15:0]        temp;
        logic [7:0]         lines;
        logic signed [15:0] abund;
    } t_request;

    typedef struct packed {
        logic [15:0]        mant;
        logic signed [7:0]  expo;
        logic               zero;
        logic signed [15:0] lrate;
        logic               high;
    } t_rate;

    typedef struct packed {
        t_request req;
        logic     has_exp;
        t_rate    exp_val;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_func = '0;
    logic [2:0] i_table_sel = '0;
    logic [6:0] i_entry_index = '0;
    logic signed [15:0] i_log_rate_value = '0;
    logic [15:0] i_log_temp = '0;
    logic [7:0] i_line_count = '0;
    logic signed [15:0] i_log_abundance = '0;
    logic i_cfg_wr_en = 1'b0;
    logic [crti_pkg::STEP_W-1:0] i_cfg_wr_data = '0;
    logic o_result_valid;
    logic [15:0] o_rate_mantissa;
    logic signed [7:0] o_rate_exponent;
    logic o_rate_is_zero;
    logic signed [15:0] o_log_rate_out;
    logic o_clamped_high;

    cooling_rate_table_interp_core #(.MAX_ENTRIES(ENTRIES)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_table_sel(i_table_sel), .i_entry_index(i_entry_index),
        .i_log_rate_value(i_log_rate_value), .i_log_temp(i_log_temp),
        .i_line_count(i_line_count), .i_log_abundance(i_log_abundance),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .o_result_valid(o_result_valid), .o_rate_mantissa(o_rate_mantissa),
        .o_rate_exponent(o_rate_exponent), .o_rate_is_zero(o_rate_is_zero),
        .o_log_rate_out(o_log_rate_out), .o_clamped_high(o_clamped_high)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [15:0] tbl_rate [8][ENTRIES];
    bit          tbl_written [8][ENTRIES];
    logic [15:0] tbl_start [8];
    logic [7:0]  tbl_lines [8];
    logic [crti_pkg::STEP_W-1:0] step_reg;
    logic [31:0] root_q30 [FB+1];

    t_rate rate_queue [$];
    int errors = 0;
    int cycles = 0;
    int queries = 0;
    int results = 0;
    int steps_used = 0;

    function automatic logic [2:0] pick_bin(logic signed [15:0] ab);
        logic [2:0] b;
        b = '0;
        for (int k = 0; k < 7; k++) if (ab > crti_pkg::ABUND_THR[k]) b++;
        return b;
    endfunction

    function automatic t_rate predict_rate(t_request q);
        t_rate o;
        logic [2:0] b;
        int n, st, sp, d, j, r, j1;
        longint x, num, y, u;
        longint unsigned m, f;
        int e;
        o = '0;
        b = pick_bin(q.abund);
        n = tbl_lines[b];
        st = tbl_start[b];
        sp = step_reg;
        if (n == 0 || int'(q.temp) < st) begin
            o.zero = 1'b1;
            return o;
        end
        d = int'(q.temp) - st;
        if (d > (n - 1) * sp) begin
            o.high = 1'b1;
            x = $signed(tbl_rate[b][n-1]);
        end else begin
            j = 0; r = 0;
            if (sp != 0) begin j = d / sp; r = d % sp; end
            j1 = (j + 1 < n) ? j + 1 : n - 1;
            if (r == 0) x = $signed(tbl_rate[b][j]);
            else begin
                num = longint'($signed(tbl_rate[b][j])) * (sp - r)
                    + longint'($signed(tbl_rate[b][j1])) * r;
                x = (num + 64'sd32768 * sp + sp / 2) / sp - 32768;
            end
        end
        y = x * longint'(crti_pkg::LOG2_10_Q30);
        u = y + (longint'(128) <<< 40);
        e = int'(u >>> 40) - 128;
        f = (u >> (40 - FB)) & ((64'd1 << FB) - 1);
        m = 64'd1 << 30;
        for (int k = 1; k <= FB; k++)
            if ((f >> (FB - k)) & 1) m = (m * root_q30[k] + (64'd1 << 29)) >> 30;
        m = (m + (64'd1 << 14)) >> 15;
        if (m >= 65536) begin m = 32768; e++; end
        o.mant = m[15:0];
        o.expo = e[7:0];
        o.lrate = x[15:0];
        return o;
    endfunction

    task automatic apply_request(t_request q);
        if (q.func == crti_pkg::FUNC_LOAD) begin
            tbl_rate[q.tsel][q.eidx] = q.rate;
            tbl_written[q.tsel][q.eidx] = 1'b1;
        end else if (q.func == crti_pkg::FUNC_SET) begin
            tbl_start[q.tsel] = q.temp;
            tbl_lines[q.tsel] = (q.lines > ENTRIES) ? 8'(ENTRIES) : q.lines;
        end
    endtask

    task automatic send_request(t_request q, bit has_exp, t_rate ev, int gap);
        t_rate p;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        {i_func, i_table_sel, i_entry_index} <= {q.func, q.tsel, q.eidx};
        i_log_rate_value <= q.rate;
        i_log_temp <= q.temp;
        i_line_count <= q.lines;
        i_log_abundance <= q.abund;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (q.func == crti_pkg::FUNC_QUERY) begin
            p = predict_rate(q);
            if (has_exp && p != ev) begin
                $display("%0t directed row predictor disagrees exp=%h pred=%h",
                         $time, ev, p);
                errors++;
            end
            rate_queue.push_back(has_exp ? ev : p);
            queries++;
        end
        apply_request(q);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_rate a, ev;
        cycles <= cycles + 1;
        if (i_rst_n && o_result_valid) begin
            a = '{o_rate_mantissa, o_rate_exponent, o_rate_is_zero,
                  o_log_rate_out, o_clamped_high};
            if (rate_queue.size() == 0) begin
                $display("%0t unexpected result %h", $time, a);
                errors++;
            end else begin
                ev = rate_queue.pop_front();
                results++;
                if (a.mant !== ev.mant) begin
                    $display("%0t mantissa exp=%h act=%h", $time, ev.mant, a.mant);
                    errors++;
                end
                if (a.expo !== ev.expo) begin
                    $display("%0t exponent exp=%0d act=%0d", $time, ev.expo, a.expo);
                    errors++;
                end
                if (a.zero !== ev.zero) begin
                    $display("%0t is_zero exp=%b act=%b", $time, ev.zero, a.zero);
                    errors++;
                end
                if (a.lrate !== ev.lrate) begin
                    $display("%0t log_rate exp=%0d act=%0d", $time, ev.lrate, a.lrate);
                    errors++;
                end
                if (a.high !== ev.high) begin
                    $display("%0t clamped exp=%b act=%b", $time, ev.high, a.high);
                    errors++;
                end
            end
        end
        if (cycles > MAX_CYCLE) begin
            $display("%0t timeout", $time);
            $display("** cooling_rate_table_interp_core: FAILED **");
            $finish;
        end
    end

    function automatic t_request mk(int fn, int ts, int ei, int rt, int tp, int ln,
                                    int ab);
        t_request q;
        q.func  = 2'(fn);
        q.tsel  = 3'(ts);
        q.eidx  = 7'(ei);
        q.rate  = 16'(rt);
        q.temp  = 16'(tp);
        q.lines = 8'(ln);
        q.abund = 16'(ab);
        return q;
    endfunction

    function automatic logic signed [15:0] abund_for(logic [2:0] b);
        logic signed [15:0] lo, hi;
        lo = (b == 0) ? -16'sd32768 : crti_pkg::ABUND_THR[b-1] + 16'sd1;
        hi = (b == 7) ? 16'sd32767 : crti_pkg::ABUND_THR[b];
        return lo + $signed(16'($urandom_range(0, int'(hi) - int'(lo))));
    endfunction

    task automatic write_step(logic [crti_pkg::STEP_W-1:0] v);
        start <= 1'b0;
        wait (rate_queue.size() == 0);
        repeat (LATENCY + 4) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        step_reg = v;
        steps_used++;
    endtask

    task automatic random_phase(int count);
        t_request q;
        logic [2:0] b;
        int sel, gap;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            q = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            if (sel < 15) q.func = crti_pkg::FUNC_LOAD;
            else if (sel < 22) begin
                q.func = crti_pkg::FUNC_SET;
                if ($urandom_range(0, 3) != 0) q.lines = 8'($urandom_range(0, 20));
                if ($urandom_range(0, 2) != 0) q.temp = 16'($urandom_range(0, 20000));
                for (int k = 0; k < q.lines && k < ENTRIES; k++)
                    if (!tbl_written[q.tsel][k]) q.lines = 8'(k);
            end else if (sel < 24) q.func = FUNC_UNUSED;
            else begin
                q.func = crti_pkg::FUNC_QUERY;
                b = 3'($urandom);
                q.abund = abund_for(b);
                if ($urandom_range(0, 4) != 0 && tbl_lines[b] != 0)
                    q.temp = 16'(int'(tbl_start[b]) + int'($urandom_range(0,
                             int'(tbl_lines[b]) * int'(step_reg) + 50)));
            end
            send_request(q, 1'b0, '0, gap);
        end
    endtask

    t_row dir_rows [$];
    t_rate zr;
    t_request rq;

    initial begin
        zr = '0; zr.zero = 1'b1;
        step_reg = 205;
        for (int k = 0; k <= FB; k++) root_q30[k] = crti_pkg::pow_root(k);
        for (int t = 0; t < 8; t++) begin
            tbl_start[t] = '0; tbl_lines[t] = '0;
            for (int e = 0; e < ENTRIES; e++) begin
                tbl_rate[t][e] = '0; tbl_written[t][e] = 1'b0;
            end
        end
        // Empty tables after reset answer zero, at both abundance extremes.
        dir_rows.push_back('{mk(crti_pkg::FUNC_QUERY, 0, 0, 0, 16'hFFFF, 0, 16'h8000),
                             1'b1, zr});
        dir_rows.push_back('{mk(crti_pkg::FUNC_QUERY, 0, 0, 0, 16'h0000, 0, 16'h7FFF),
                             1'b1, zr});
        dir_rows.push_back('{mk(crti_pkg::FUNC_LOAD, 3, 0, 16'h0000, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_LOAD, 3, 1, 16'h7FFF, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_LOAD, 3, 2, 16'h8000, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_LOAD, 3, 127, 16'h0400, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_SET, 3, 0, 0, 1000, 3, 0), 1'b0, '0});
        dir_rows.push_back('{mk(FUNC_UNUSED, 3, 0, 0, 0, 0, 0), 1'b0, '0});
        // Below start, on a point, between points, above the last point.
        dir_rows.push_back('{mk(crti_pkg::FUNC_QUERY, 0, 0, 0, 999, 0, -6000), 1'b1, zr});
        dir_rows.push_back('{mk(crti_pkg::FUNC_QUERY, 0, 0, 0, 1000, 0, -6000), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_QUERY, 0, 0, 0, 1100, 0, -6000), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_QUERY, 0, 0, 0, 1300, 0, -5120), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_QUERY, 0, 0, 0, 1410, 0, -7167), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_QUERY, 0, 0, 0, 16'hFFFF, 0, -5121),
                             1'b0, '0});
        // Oversized line count saturates; one line clamps the upper index.
        dir_rows.push_back('{mk(crti_pkg::FUNC_SET, 3, 0, 0, 0, 255, 0), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_QUERY, 0, 0, 0, 16'hFFFF, 0, -6000),
                             1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_SET, 3, 0, 0, 500, 1, 0), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_QUERY, 0, 0, 0, 500, 0, -6000), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_QUERY, 0, 0, 0, 501, 0, -6000), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_SET, 3, 0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk(crti_pkg::FUNC_QUERY, 0, 0, 0, 500, 0, -6000), 1'b1, zr});

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].has_exp, dir_rows[i].exp_val,
                         $urandom_range(0, 2));
        // Fill the leading entries of every table so queries never read an
        // unwritten entry; line counts are kept within the written prefix.
        for (int t = 0; t < 8; t++)
            for (int e = 0; e < FILL; e++) begin
                rq = mk(crti_pkg::FUNC_LOAD, t, e, $urandom, 0, 0, 0);
                send_request(rq, 1'b0, '0, 0);
            end
        for (int t = 0; t < 8; t++) begin
            rq = mk(crti_pkg::FUNC_SET, t, 0, 0, $urandom_range(0, 20000),
                    $urandom_range(1, 20), 0);
            send_request(rq, 1'b0, '0, 0);
        end
        random_phase(200);
        write_step(12'd1);
        random_phase(200);
        write_step(12'd4095);
        random_phase(200);
        write_step(12'd0);
        random_phase(150);
        write_step(12'($urandom_range(2, 4094)));
        random_phase(250);

        start <= 1'b0;
        wait (rate_queue.size() == 0);
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("Run covered %0d queries, %0d results checked, over %0d step settings.",
                 queries, results, steps_used + 1);
        if (errors == 0 && rate_queue.size() == 0) begin
            $display("** cooling_rate_table_interp_core: PASSED **");
        end else begin
            $display("** cooling_rate_table_interp_core: FAILED **");
        end
        $finish;
    end
endmodule
